// ===== rtl/core/psdlv_pkg.sv =====
package psdlv_pkg;

   localparam int MAX_DELAY_DEF   = 1024;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CMD_BITS       = 2;
   localparam int INDEX_BITS     = 10;
   localparam int EXC_BITS       = 16;
   localparam int MIX_BITS       = 18;
   localparam int OUT_BITS       = 18;
   localparam int LEN_BITS       = 11;
   localparam int GAIN_BITS      = 17;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [LEN_BITS-1:0]  LEN_RESET = 11'd100;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 17'd65536;

   localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_PLUCK = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELAY_LENGTH = 2'd0,
      CSR_DECAY_GAIN   = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PLUCK,
      ST_TICK_POS,
      ST_TICK_CUR,
      ST_TICK_OUT,
      ST_TICK_SUM,
      ST_TICK_MUL,
      ST_TICK_WR
   } state_type;

   typedef enum logic {
      ALU_MIX,
      ALU_PAIR
   } alu_op_type;

   typedef struct packed {
      logic accept;
      logic cmd_pluck;
      logic cmd_tick;
      logic out_free;
   } ctrl_status_type;

   typedef struct packed {
      logic       ready;
      logic       clearing;
      logic       pluck_wr;
      logic       rd_pos;
      logic       cur_cap;
      logic       out_load;
      logic       sum_load;
      logic       prod_load;
      logic       tick_wr;
      alu_op_type alu_op;
   } ctrl_type;

endpackage

// ===== rtl/core/plucked_string_delay_line_voice.sv =====
// Channel   Ports                                  Transfer when
// request   req_valid/req_stall + 4 fields         req_valid && !req_stall
// response  rsp_valid/rsp_stall + rsp_sample_out   rsp_valid && !rsp_stall
// csr       csr_we/csr_index/csr_wdata             csr_we
//
// Pluck copies delay length entries, one per cycle through the
// excitation RAM read port. Tick steps are set by the shared adder and the
// delay RAM's single read port (two reads, two adds, multiply, write-back).
// After reset a clearing pass zeroes the delay line; requests stall meanwhile.
// A stalled response holds a tick in its output step.
module plucked_string_delay_line_voice #(
   parameter int MAX_DELAY   = psdlv_pkg::MAX_DELAY_DEF,
   parameter int SAMPLE_BITS = psdlv_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [psdlv_pkg::CMD_BITS-1:0]             req_command,
   input  logic [psdlv_pkg::INDEX_BITS-1:0]           req_entry_index,
   input  logic signed [psdlv_pkg::EXC_BITS-1:0]      req_excitation_value,
   input  logic signed [psdlv_pkg::MIX_BITS-1:0]      req_mix_in,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [psdlv_pkg::OUT_BITS-1:0]      rsp_sample_out,
   input  logic                                       csr_we,
   input  logic [psdlv_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [psdlv_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);

   localparam int SB   = SAMPLE_BITS;
   localparam int AW   = $clog2(MAX_DELAY);
   localparam int CW   = $clog2(MAX_DELAY+1);
   localparam int LB   = psdlv_pkg::LEN_BITS;
   localparam int GB   = psdlv_pkg::GAIN_BITS;
   localparam int IB   = psdlv_pkg::INDEX_BITS;
   localparam int EB   = psdlv_pkg::EXC_BITS;
   localparam int MB   = psdlv_pkg::MIX_BITS;
   localparam int OB   = psdlv_pkg::OUT_BITS;
   localparam int CMPW = (CW > LB) ? CW : LB;
   localparam int XW   = (CW > IB) ? CW : IB;
   localparam int W    = (SB > MB) ? SB : MB;
   localparam int PW   = SB + 19;

   psdlv_pkg::ctrl_type        ctrl;
   psdlv_pkg::ctrl_status_type status;
   logic [CW-1:0]              cnt;
   logic [CW-1:0]              cnt_m1;

   logic [LB-1:0]              dl_ff, dl_in;
   logic [GB-1:0]              gain_ff, gain_in;
   logic [GB-1:0]              gain_use;
   logic [CMPW-1:0]            dl_x;
   logic [CW-1:0]              len_use;

   logic [AW-1:0]              pos_ff, pos_in;
   logic [AW-1:0]              pos_eff;
   logic [CW-1:0]              pos_p1;
   logic [AW-1:0]              nxt_pos;
   logic [AW-1:0]              nxt_pos_ff, nxt_pos_in;

   logic signed [MB-1:0]       mix_ff, mix_in;
   logic signed [SB-1:0]       cur_ff, cur_in;
   logic signed [SB-1:0]       nxt_val_ff, nxt_val_in;
   logic signed [SB:0]         sum_ff, sum_in;
   logic signed [PW-1:0]       prod_ff, prod_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OB-1:0]       rsp_sample_ff, rsp_sample_in;

   logic                       accept;
   logic                       load_ok;
   logic                       exc_we;
   logic [AW-1:0]              exc_waddr;
   logic [SB-1:0]              exc_wdata;
   logic [SB-1:0]              exc_rdata;

   logic                       dly_we;
   logic [AW-1:0]              dly_waddr;
   logic [SB-1:0]              dly_wdata;
   logic [AW-1:0]              dly_raddr;
   logic [SB-1:0]              dly_rdata;

   logic signed [EB-1:0]       cur16;
   logic signed [W:0]          alu_sum;
   logic signed [OB-1:0]       alu_sat;

   // Configuration and lengths
   assign dl_in   = (csr_we && csr_index == psdlv_pkg::CSR_DELAY_LENGTH)
                    ? csr_wdata[LB-1:0] : dl_ff;
   assign gain_in = (csr_we && csr_index == psdlv_pkg::CSR_DECAY_GAIN)
                    ? csr_wdata[GB-1:0] : gain_ff;

   assign gain_use = (gain_ff > psdlv_pkg::GAIN_ONE) ? psdlv_pkg::GAIN_ONE : gain_ff;
   assign dl_x     = CMPW'(dl_ff);

   always_comb begin
      priority if (dl_x == '0) begin
         len_use = CW'(1);
      end else if (dl_x > CMPW'(MAX_DELAY)) begin
         len_use = CW'(MAX_DELAY);
      end else begin
         len_use = dl_x[CW-1:0];
      end
   end

   // Handshake
   assign req_stall        = !ctrl.ready;
   assign accept           = req_valid && ctrl.ready;
   assign status.accept    = accept;
   assign status.cmd_pluck = (req_command == psdlv_pkg::CMD_PLUCK);
   assign status.cmd_tick  = (req_command == psdlv_pkg::CMD_TICK);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   psdlv_ctrl #(
      .MAX_DELAY(MAX_DELAY)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .len_use(len_use),
      .ctrl   (ctrl),
      .cnt    (cnt)
   );

   // Excitation store
   assign load_ok   = XW'(req_entry_index) < XW'(MAX_DELAY);
   assign exc_we    = accept && (req_command == psdlv_pkg::CMD_LOAD) && load_ok;
   assign exc_waddr = AW'(XW'(req_entry_index));

   generate
      if (SB > EB) begin : g_load_up
         assign exc_wdata = {req_excitation_value, {(SB-EB){1'b0}}};
         assign cur16     = cur_ff[SB-1:SB-EB];
      end else if (SB < EB) begin : g_load_down
         assign exc_wdata = req_excitation_value[EB-1:EB-SB];
         assign cur16     = {cur_ff, {(EB-SB){1'b0}}};
      end else begin : g_load_same
         assign exc_wdata = req_excitation_value;
         assign cur16     = cur_ff;
      end
   endgenerate

   psdlv_ram #(
      .WIDTH(SB),
      .DEPTH(MAX_DELAY)
   ) u_exc_ram (
      .clock(clock),
      .we   (exc_we),
      .waddr(exc_waddr),
      .wdata(exc_wdata),
      .raddr(cnt[AW-1:0]),
      .rdata(exc_rdata)
   );

   // Positions
   always_comb begin
      pos_eff = (CW'(pos_ff) >= len_use) ? '0 : pos_ff;
      pos_p1  = CW'(pos_eff) + CW'(1);
      nxt_pos = (pos_p1 >= len_use) ? '0 : pos_p1[AW-1:0];
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept && status.cmd_pluck) begin
         pos_in = '0;
      end else if (ctrl.tick_wr) begin
         pos_in = nxt_pos_ff;
      end
   end

   assign nxt_pos_in = ctrl.rd_pos ? nxt_pos : nxt_pos_ff;

   // Delay line
   assign cnt_m1    = cnt - CW'(1);
   assign dly_we    = ctrl.clearing || ctrl.pluck_wr || ctrl.tick_wr;
   assign dly_raddr = ctrl.rd_pos ? pos_eff : nxt_pos_ff;

   always_comb begin
      priority if (ctrl.clearing) begin
         dly_waddr = cnt[AW-1:0];
         dly_wdata = '0;
      end else if (ctrl.pluck_wr) begin
         dly_waddr = cnt_m1[AW-1:0];
         dly_wdata = exc_rdata;
      end else begin
         dly_waddr = nxt_pos_ff;
         dly_wdata = prod_ff[SB+16:17];
      end
   end

   psdlv_ram #(
      .WIDTH(SB),
      .DEPTH(MAX_DELAY)
   ) u_dly_ram (
      .clock(clock),
      .we   (dly_we),
      .waddr(dly_waddr),
      .wdata(dly_wdata),
      .raddr(dly_raddr),
      .rdata(dly_rdata)
   );

   // Shared adder
   psdlv_alu #(
      .W(W)
   ) u_alu (
      .op       (ctrl.alu_op),
      .mix_w    (W'(mix_ff)),
      .cur_out_w(W'(cur16)),
      .cur_w    (W'(cur_ff)),
      .nxt_w    (W'(nxt_val_ff)),
      .sum      (alu_sum),
      .sat      (alu_sat)
   );

   // Datapath registers
   assign mix_in        = accept ? req_mix_in : mix_ff;
   assign cur_in        = ctrl.cur_cap ? dly_rdata : cur_ff;
   assign nxt_val_in    = ctrl.out_load ? dly_rdata : nxt_val_ff;
   assign sum_in        = ctrl.sum_load ? alu_sum[SB:0] : sum_ff;
   assign prod_in       = ctrl.prod_load ? (sum_ff * $signed({1'b0, gain_use})) : prod_ff;
   assign rsp_sample_in = ctrl.out_load ? alu_sat : rsp_sample_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff        <= psdlv_pkg::LEN_RESET;
         gain_ff      <= psdlv_pkg::GAIN_ONE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dl_ff        <= dl_in;
         gain_ff      <= gain_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_pos_ff    <= nxt_pos_in;
      mix_ff        <= mix_in;
      cur_ff        <= cur_in;
      nxt_val_ff    <= nxt_val_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // Checks
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.out_load))
      else $error("response raised without a tick result");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.clearing |-> req_stall)
      else $error("request taken during delay line clear");

   a_wb_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.tick_wr |-> (CW'(nxt_pos_ff) < len_use))
      else $error("loop write-back beyond delay length");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.clearing, ctrl.pluck_wr, ctrl.tick_wr}))
      else $error("delay line written by two sources");

endmodule

// ===== rtl/core/psdlv_ram.sv =====
module psdlv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/psdlv_alu.sv =====
module psdlv_alu #(
   parameter int W = 18
) (
   input  psdlv_pkg::alu_op_type                  op,
   input  logic signed [W-1:0]                    mix_w,
   input  logic signed [W-1:0]                    cur_out_w,
   input  logic signed [W-1:0]                    cur_w,
   input  logic signed [W-1:0]                    nxt_w,
   output logic signed [W:0]                      sum,
   output logic signed [psdlv_pkg::OUT_BITS-1:0]  sat
);

   localparam int OB = psdlv_pkg::OUT_BITS;

   logic signed [W-1:0] op_a;
   logic signed [W-1:0] op_b;
   logic [W-OB+1:0]     top_bits;

   always_comb begin
      unique case (op)
         psdlv_pkg::ALU_MIX: begin
            op_a = mix_w;
            op_b = cur_out_w;
         end
         psdlv_pkg::ALU_PAIR: begin
            op_a = cur_w;
            op_b = nxt_w;
         end
      endcase
   end

   assign sum      = (W+1)'(op_a) + (W+1)'(op_b);
   assign top_bits = sum[W:OB-1];

   always_comb begin
      if ((&top_bits) || (~|top_bits)) begin
         sat = sum[OB-1:0];
      end else if (sum[W]) begin
         sat = psdlv_pkg::OUT_MIN;
      end else begin
         sat = psdlv_pkg::OUT_MAX;
      end
   end

endmodule

// ===== rtl/core/psdlv_ctrl.sv =====
module psdlv_ctrl #(
   parameter int MAX_DELAY = psdlv_pkg::MAX_DELAY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  psdlv_pkg::ctrl_status_type         status,
   input  logic [$clog2(MAX_DELAY+1)-1:0]     len_use,
   output psdlv_pkg::ctrl_type                ctrl,
   output logic [$clog2(MAX_DELAY+1)-1:0]     cnt
);

   localparam int CW = $clog2(MAX_DELAY+1);

   psdlv_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psdlv_pkg::ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      unique case (state_ff)
         psdlv_pkg::ST_CLEAR: begin
            if (cnt_ff == CW'(MAX_DELAY-1)) begin
               state_in = psdlv_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         psdlv_pkg::ST_IDLE: begin
            if (status.accept && status.cmd_pluck) begin
               state_in = psdlv_pkg::ST_PLUCK;
            end else if (status.accept && status.cmd_tick) begin
               state_in = psdlv_pkg::ST_TICK_POS;
            end
         end
         psdlv_pkg::ST_PLUCK: begin
            if (cnt_ff == len_use) begin
               state_in = psdlv_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         psdlv_pkg::ST_TICK_POS: state_in = psdlv_pkg::ST_TICK_CUR;
         psdlv_pkg::ST_TICK_CUR: state_in = psdlv_pkg::ST_TICK_OUT;
         psdlv_pkg::ST_TICK_OUT: begin
            if (status.out_free) begin
               state_in = psdlv_pkg::ST_TICK_SUM;
            end
         end
         psdlv_pkg::ST_TICK_SUM: state_in = psdlv_pkg::ST_TICK_MUL;
         psdlv_pkg::ST_TICK_MUL: state_in = psdlv_pkg::ST_TICK_WR;
         psdlv_pkg::ST_TICK_WR:  state_in = psdlv_pkg::ST_IDLE;
         default:                state_in = psdlv_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.alu_op    = psdlv_pkg::ALU_MIX;
      ctrl.ready     = (state_ff == psdlv_pkg::ST_IDLE);
      ctrl.clearing  = (state_ff == psdlv_pkg::ST_CLEAR);
      ctrl.pluck_wr  = (state_ff == psdlv_pkg::ST_PLUCK) && (cnt_ff != '0);
      ctrl.rd_pos    = (state_ff == psdlv_pkg::ST_TICK_POS);
      ctrl.cur_cap   = (state_ff == psdlv_pkg::ST_TICK_CUR);
      ctrl.out_load  = (state_ff == psdlv_pkg::ST_TICK_OUT) && status.out_free;
      ctrl.sum_load  = (state_ff == psdlv_pkg::ST_TICK_SUM);
      ctrl.prod_load = (state_ff == psdlv_pkg::ST_TICK_MUL);
      ctrl.tick_wr   = (state_ff == psdlv_pkg::ST_TICK_WR);
      if (state_ff == psdlv_pkg::ST_TICK_SUM) begin
         ctrl.alu_op = psdlv_pkg::ALU_PAIR;
      end
   end

   assign cnt = cnt_ff;

endmodule
